[rtl/slcd_pkg.sv]
// Shared types for the sync/length/checksum deframer.
// Holds the phase and result-kind enums; no dependencies.
package slcd_pkg;

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_BODY    = 3'd3,
        PH_CHECK   = 3'd4,
        PH_TRAILER = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BODY  = 2'd0,
        KIND_GOOD  = 2'd1,
        KIND_BAD   = 2'd2,
        KIND_START = 2'd3
    } t_kind;

    localparam logic [7:0] SYNC_RESET = 8'hFF;

endpackage

[rtl/sync_length_checksum_deframer.sv]
// Byte-wise frame deframer: sync, sync, length, body, checksum, trailer.
// Depends on slcd_pkg (phase and result-kind enums, sync reset value).
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_rx_byte) carries one received
//   byte per beat. Output channel (o_out_valid / i_out_ready / o_*) carries
//   at most one result beat per input beat: a body byte with its index, a
//   frame verdict (good / checksum mismatch) on the trailer byte, or a
//   bad-start report when the second sync byte is wrong.
//   A frame is length+5 bytes; the checksum byte is the inverse of the 8-bit
//   sum of the length and body bytes.
//   i_cfg_wr_en / i_cfg_wr_data write the sync value; it takes effect on the
//   next sync comparison.
//
// Timing:
//   A result appears in the output register the cycle after its byte is
//   taken. Throughput is one byte per cycle while the output is not stalled;
//   the phase update and the 8-bit add feed the frame state registers, beside
//   the result logic that loads the output register.
//   The input is taken whenever the output register is empty or being
//   drained, so a stalled receiver back-pressures the input one-for-one.
//   Reset (synchronous, active low) empties the output register, returns to
//   hunting for the first sync byte and restores the sync value to 0xFF.
module sync_length_checksum_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    // input byte channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_result_kind,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_byte_index,
    output logic [7:0] o_frame_type,
    output logic [7:0] o_frame_length,
    output logic       o_last
);

    // frame state
    slcd_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_sync;
    logic [7:0]       r_body_length, n_body_length;
    logic [7:0]       r_body_count, n_body_count;
    logic [7:0]       r_running_sum, n_running_sum;
    logic [7:0]       r_type_byte, n_type_byte;
    logic             r_sum_matched, n_sum_matched;

    // result register
    logic             r_out_valid;
    slcd_pkg::t_kind  r_kind, n_kind;
    logic [7:0]       r_data, n_data;
    logic [7:0]       r_index, n_index;
    logic [7:0]       r_mtype, n_mtype;
    logic [7:0]       r_flen, n_flen;
    logic             r_last, n_last;
    logic             n_emit;

    logic             in_fire;
    logic [7:0]       body_count_inc;

    // output register is free when empty or draining this cycle
    assign o_in_ready     = !r_out_valid || i_out_ready;
    assign in_fire        = i_in_valid && o_in_ready;
    assign body_count_inc = r_body_count + 8'd1;

    // next frame state
    always_comb begin
        n_phase       = r_phase;
        n_body_length = r_body_length;
        n_body_count  = r_body_count;
        n_running_sum = r_running_sum;
        n_type_byte   = r_type_byte;
        n_sum_matched = r_sum_matched;
        case (r_phase)
            slcd_pkg::PH_HUNT2: begin
                n_phase = (i_rx_byte == r_sync) ? slcd_pkg::PH_LENGTH : slcd_pkg::PH_HUNT1;
            end
            slcd_pkg::PH_LENGTH: begin
                n_body_length = i_rx_byte;
                n_body_count  = 8'd0;
                n_running_sum = i_rx_byte;
                n_type_byte   = 8'd0;
                n_sum_matched = 1'b0;
                n_phase = (i_rx_byte == 8'd0) ? slcd_pkg::PH_CHECK : slcd_pkg::PH_BODY;
            end
            slcd_pkg::PH_BODY: begin
                if (r_body_count == 8'd0) begin
                    n_type_byte = i_rx_byte;
                end
                n_running_sum = r_running_sum + i_rx_byte;
                n_body_count  = body_count_inc;
                if (body_count_inc == r_body_length) begin
                    n_phase = slcd_pkg::PH_CHECK;
                end
            end
            slcd_pkg::PH_CHECK: begin
                n_sum_matched = (~r_running_sum == i_rx_byte);
                n_phase       = slcd_pkg::PH_TRAILER;
            end
            slcd_pkg::PH_TRAILER: begin
                n_phase = slcd_pkg::PH_HUNT1;
            end
            default: begin
                n_phase = (i_rx_byte == r_sync) ? slcd_pkg::PH_HUNT2 : slcd_pkg::PH_HUNT1;
            end
        endcase
    end

    // result for the current byte
    always_comb begin
        n_emit  = 1'b0;
        n_kind  = slcd_pkg::KIND_BODY;
        n_data  = 8'd0;
        n_index = 8'd0;
        n_mtype = 8'd0;
        n_flen  = 8'd0;
        n_last  = 1'b0;
        case (r_phase)
            slcd_pkg::PH_HUNT2: begin
                if (i_rx_byte != r_sync) begin
                    n_emit = 1'b1;
                    n_kind = slcd_pkg::KIND_START;
                    n_last = 1'b1;
                end
            end
            slcd_pkg::PH_BODY: begin
                n_emit  = 1'b1;
                n_kind  = slcd_pkg::KIND_BODY;
                n_data  = i_rx_byte;
                n_index = r_body_count;
                n_mtype = n_type_byte;
                n_flen  = r_body_length;
            end
            slcd_pkg::PH_TRAILER: begin
                n_emit  = 1'b1;
                n_kind  = r_sum_matched ? slcd_pkg::KIND_GOOD : slcd_pkg::KIND_BAD;
                n_mtype = r_type_byte;
                n_flen  = r_body_length;
                n_last  = 1'b1;
            end
            default: begin
                n_emit = 1'b0;
            end
        endcase
    end

    // state and sync register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= slcd_pkg::PH_HUNT1;
            r_sync        <= slcd_pkg::SYNC_RESET;
            r_body_length <= 8'd0;
            r_body_count  <= 8'd0;
            r_running_sum <= 8'd0;
            r_type_byte   <= 8'd0;
            r_sum_matched <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_sync <= i_cfg_wr_data;
            end
            if (in_fire) begin
                r_phase       <= n_phase;
                r_body_length <= n_body_length;
                r_body_count  <= n_body_count;
                r_running_sum <= n_running_sum;
                r_type_byte   <= n_type_byte;
                r_sum_matched <= n_sum_matched;
            end
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= in_fire && n_emit;
        end
    end

    // output payload, loaded only with a new result
    always_ff @(posedge i_clk) begin
        if (in_fire && n_emit) begin
            r_kind  <= n_kind;
            r_data  <= n_data;
            r_index <= n_index;
            r_mtype <= n_mtype;
            r_flen  <= n_flen;
            r_last  <= n_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_kind;
    assign o_data_byte    = r_data;
    assign o_byte_index   = r_index;
    assign o_frame_type   = r_mtype;
    assign o_frame_length = r_flen;
    assign o_last         = r_last;

    // body phase never runs past the length byte
    a_body_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == slcd_pkg::PH_BODY |-> r_body_count < r_body_length)
        else $error("body count reached length while still in body phase");

    // body beats never end a frame, verdicts always do
    a_last_matches_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_result_kind != slcd_pkg::KIND_BODY)))
        else $error("last flag disagrees with result kind");

    // bad start carries no frame info
    a_bad_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == slcd_pkg::KIND_START
        |-> o_frame_type == 8'd0 && o_frame_length == 8'd0)
        else $error("bad-start beat carries frame fields");

    // wrong second sync byte reports bad start next cycle
    a_bad_sync_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && r_phase == slcd_pkg::PH_HUNT2 && i_rx_byte != r_sync
        |=> o_out_valid && o_result_kind == slcd_pkg::KIND_START)
        else $error("bad second sync byte not reported");

endmodule

[test/sync_length_checksum_deframer_test.sv]
// Self-checking bench for sync_length_checksum_deframer: byte stream in, result beats out.
// A clocked driver and monitor run around an in-bench frame predictor.
// Depends on slcd_pkg for the phase and result-kind enums and the sync reset value.
`timescale 1ns / 100ps

module sync_length_checksum_deframer_test;

    localparam int CYCLE_LIMIT = 500_000;
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off, fills the block

    // one expected result beat
    typedef struct {
        slcd_pkg::t_kind kind;
        logic [7:0]      data;
        logic [7:0]      pos;
        logic [7:0]      mtype;
        logic [7:0]      flen;
        logic            last_beat;
    } t_result_beat;

    // ---------------------------------------------------------------- DUT I/O
    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte     = 8'h00;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [1:0] result_kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic       last;

    sync_length_checksum_deframer i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_result_kind  (result_kind),
        .o_data_byte    (data_byte),
        .o_byte_index   (byte_index),
        .o_frame_type   (frame_type),
        .o_frame_length (frame_length),
        .o_last         (last)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------- bench state
    logic [7:0]   rx_bytes_pending[$];   // bytes still to be offered
    t_result_beat expected_beats[$];     // predicted beats not yet seen
    int           mismatches  = 0;
    int           cycle_count = 0;
    int           idle_pct    = 10;      // chance (percent) of starting an idle burst
    bit           calm        = 1'b0;    // no idling at all when set
    logic         hold_req    = 1'b0;    // asks for the one long receiver hold-off
    bit           hold_done   = 1'b0;
    int           hold_left   = 0;
    int           send_gap    = 0;
    int           recv_gap    = 0;

    // deframer shadow state
    logic [7:0]       sync_val = slcd_pkg::SYNC_RESET;
    slcd_pkg::t_phase ph       = slcd_pkg::PH_HUNT1;
    logic [7:0]       blen     = 8'h00;
    logic [7:0]       bcnt     = 8'h00;
    logic [7:0]       rsum     = 8'h00;
    logic [7:0]       mtype    = 8'h00;
    bit               sum_ok   = 1'b0;

    // Advance the shadow deframer by one accepted byte; queue the beat it causes.
    task automatic deframe_byte(input logic [7:0] b);
        t_result_beat r;
        logic [7:0]   inv_sum;
        r = '{kind: slcd_pkg::KIND_BODY, data: 8'h00, pos: 8'h00, mtype: 8'h00,
              flen: 8'h00, last_beat: 1'b0};
        inv_sum = ~rsum;
        case (ph)
            slcd_pkg::PH_HUNT2: begin
                if (b == sync_val) begin
                    ph = slcd_pkg::PH_LENGTH;
                end else begin
                    // second start byte wrong: report and drop
                    ph = slcd_pkg::PH_HUNT1;
                    r.kind = slcd_pkg::KIND_START;
                    r.last_beat = 1'b1;
                    expected_beats.push_back(r);
                end
            end
            slcd_pkg::PH_LENGTH: begin
                blen   = b;
                bcnt   = 8'h00;
                rsum   = b;
                mtype  = 8'h00;
                sum_ok = 1'b0;
                ph     = (b == 8'h00) ? slcd_pkg::PH_CHECK : slcd_pkg::PH_BODY;
            end
            slcd_pkg::PH_BODY: begin
                if (bcnt == 8'h00) mtype = b;
                rsum  = rsum + b;
                r.data = b;
                r.pos  = bcnt;
                bcnt  = bcnt + 8'h01;
                if (bcnt == blen) ph = slcd_pkg::PH_CHECK;
                r.mtype = mtype;
                r.flen  = blen;
                expected_beats.push_back(r);
            end
            slcd_pkg::PH_CHECK: begin
                // verdict is held until the trailer byte
                sum_ok = (inv_sum == b);
                ph     = slcd_pkg::PH_TRAILER;
            end
            slcd_pkg::PH_TRAILER: begin
                ph = slcd_pkg::PH_HUNT1;
                r.kind      = sum_ok ? slcd_pkg::KIND_GOOD : slcd_pkg::KIND_BAD;
                r.mtype     = mtype;
                r.flen      = blen;
                r.last_beat = 1'b1;
                expected_beats.push_back(r);
            end
            default: begin
                ph = (b == sync_val) ? slcd_pkg::PH_HUNT2 : slcd_pkg::PH_HUNT1;
            end
        endcase
    endtask

    // -------------------------------------------------------------- driver
    // Valid is held with the byte steady until the beat is taken; idle bursts
    // are only started between beats.
    always @(posedge clk) begin : byte_driver
        bit taken;
        taken = in_valid && in_ready;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (taken) deframe_byte(rx_byte);
            if (!in_valid || taken) begin
                if (send_gap != 0 && !calm) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (rx_bytes_pending.size() != 0) begin
                    rx_byte  <= rx_bytes_pending.pop_front();
                    in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 99) < idle_pct)
                        send_gap <= $urandom_range(1, 15);
                    else
                        send_gap <= 0;
                end else begin
                    in_valid <= 1'b0;
                    send_gap <= 0;
                end
            end
        end
    end

    // Long hold-off, counted here on its own once requested.
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver ready with random idle bursts, held low during the long hold-off.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end else if (hold_left != 0) begin
            out_ready <= 1'b0;
        end else if (calm) begin
            out_ready <= 1'b1;
            recv_gap  <= 0;
        end else if (recv_gap != 0) begin
            out_ready <= 1'b0;
            recv_gap  <= recv_gap - 1;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            out_ready <= 1'b0;
            recv_gap  <= $urandom_range(0, 14);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------- monitor
    always @(posedge clk) begin : beat_monitor
        t_result_beat want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_beats.size() == 0) begin
                if (mismatches < 10)
                    $display(
                        "unexpected beat: kind %0d data %02h idx %0d type %02h len %0d last %0b",
                        result_kind, data_byte, byte_index, frame_type, frame_length, last);
                mismatches++;
            end else begin
                want = expected_beats.pop_front();
                if (result_kind !== want.kind || data_byte !== want.data ||
                    byte_index !== want.pos || frame_type !== want.mtype ||
                    frame_length !== want.flen || last !== want.last_beat) begin
                    if (mismatches < 10) begin
                        $display(
                            "mismatch exp: kind %0d data %02h idx %0d type %02h len %0d last %0b",
                            want.kind, want.data, want.pos, want.mtype, want.flen,
                            want.last_beat);
                        $display(
                            "         got: kind %0d data %02h idx %0d type %02h len %0d last %0b",
                            result_kind, data_byte, byte_index, frame_type, frame_length,
                            last);
                    end
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------- timeout
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** sync_length_checksum_deframer: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------ stimulus
    // One frame at the current sync value, optionally broken at the second
    // start byte or at the checksum.
    task automatic queue_frame(input int len, input bit bad_start, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        int         k;
        rx_bytes_pending.push_back(sync_val);
        if (bad_start) begin
            rx_bytes_pending.push_back(sync_val ^ 8'($urandom_range(1, 255)));
        end else begin
            rx_bytes_pending.push_back(sync_val);
            rx_bytes_pending.push_back(8'(len));
            sum = 8'(len);
            for (k = 0; k < len; k++) begin
                b = 8'($urandom);
                sum = sum + b;
                rx_bytes_pending.push_back(b);
            end
            b = ~sum;
            if (bad_sum) b = b ^ 8'($urandom_range(1, 255));
            rx_bytes_pending.push_back(b);
            rx_bytes_pending.push_back(8'($urandom));  // trailer, any value
        end
    endtask

    // Mostly well-formed frames of small length, some broken ones and noise.
    task automatic queue_random_bytes(input int count);
        int stop;
        int pick;
        int len;
        int k;
        stop = rx_bytes_pending.size() + count;
        while (rx_bytes_pending.size() < stop) begin
            pick = $urandom_range(0, 99);
            len  = $urandom_range(0, 99);
            if (len < 2)      len = 255;
            else if (len < 6) len = $urandom_range(9, 254);
            else              len = $urandom_range(0, 8);
            if (pick < 70)      queue_frame(len, 1'b0, 1'b0);
            else if (pick < 80) queue_frame(len, 1'b0, 1'b1);
            else if (pick < 88) queue_frame(len, 1'b1, 1'b0);
            else begin
                for (k = 0; k < $urandom_range(1, 4); k++)
                    rx_bytes_pending.push_back(8'($urandom));
            end
        end
    endtask

    // Sender pause: everything offered, taken and answered, plus a further wait
    // for a trailing byte that causes no beat.
    task automatic wait_drained();
        do @(negedge clk);
        while (rx_bytes_pending.size() != 0 || in_valid || expected_beats.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_sync(input logic [7:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sync_val = value;
        @(negedge clk);
    endtask

    initial begin
        int p;
        logic [7:0] sv;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed beats at the reset sync value 0xFF
        rx_bytes_pending.push_back(8'h00);                       // wrong first byte
        rx_bytes_pending = {rx_bytes_pending,
            8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h3C,                  // zero length, good
            8'hFF, 8'h00,                                       // wrong second sync
            8'hFF, 8'hFF, 8'h01, 8'hFF, 8'h00, 8'hC3,           // one body byte, bad sum
            8'hFF, 8'hFF, 8'h02, 8'h00, 8'h80, 8'h7D, 8'hFF};   // two body bytes, good
        queue_random_bytes(230);
        wait_drained();

        for (p = 1; p <= 5; p++) begin
            case (p)
                1:       sv = 8'h00;
                3:       sv = 8'hFF;
                4:       sv = 8'h80;
                default: sv = 8'($urandom);
            endcase
            write_sync(sv);
            idle_pct = (p == 3) ? 0 : $urandom_range(5, 30);
            calm     = (p == 5);
            queue_random_bytes(250);
            if (p == 2) begin
                // receiver stalls while bytes keep coming
                repeat (40) @(posedge clk);
                hold_req <= 1'b1;
            end
            wait_drained();
        end

        repeat (10) @(negedge clk);
        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("** sync_length_checksum_deframer: PASSED **");
        end else begin
            $display("** sync_length_checksum_deframer: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/slcd_pkg.sv
rtl/sync_length_checksum_deframer.sv
test/sync_length_checksum_deframer_test.sv
